[src/pllm_pkg.sv]
// Package for the pooled linked list manager: sizes, field widths,
// operation and status codes. No dependencies.
`timescale 1ns / 1ps

package pllm_pkg;

    localparam int MAX_LISTS  = 8;
    localparam int POOL_NODES = 128;
    localparam int ITEM_WIDTH = 32;

    // field widths of one request and one result
    localparam int OP_W     = 3;
    localparam int LID_W    = 3;
    localparam int ITEM_IN_W = 32;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 8;

    localparam int IN_BITS      = OP_W + 2 * LID_W + ITEM_IN_W;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS     = STATUS_W + LID_W + LEN_W;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // pointers hold 0..POOL_NODES, POOL_NODES meaning null
    localparam int PTR_W = $clog2(POOL_NODES + 1);
    localparam int IDX_W = $clog2(POOL_NODES);
    localparam int CNT_W = $clog2(POOL_NODES + 1);
    localparam int LC_W  = $clog2(MAX_LISTS + 1);
    localparam int LIX_W = $clog2(MAX_LISTS);

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_ptr NIL = t_ptr'(POOL_NODES);

    typedef enum logic [OP_W-1:0] {
        OP_CREATE  = 3'd0,
        OP_ADD     = 3'd1,
        OP_INSERT  = 3'd2,
        OP_APPEND  = 3'd3,
        OP_PREPEND = 3'd4,
        OP_CONCAT  = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_NO_LIST    = 3'd1,
        ST_POOL_FULL  = 3'd2,
        ST_TABLE_FULL = 3'd3,
        ST_SAME_LIST  = 3'd4
    } t_status;

endpackage

[src/pooled_linked_list_manager_top.sv]
// Pooled doubly linked list manager: list table in flops, node links and
// items in synchronous memories. Uses pllm_pkg.
//
// Result register loaded in S_FIN, straight after S_DEC for create, errors
// and inserts into an empty list or at a null anchor; after S_LINK1 for
// linking inserts (node read issued in S_DEC, new node's links written in
// S_LINK1, anchor/neighbor links and item in S_FIN); after S_CATB for
// concat (list B read). A new request is taken only in S_IDLE, once the last
// is committed; a result held by m_axis_tready stalls the request in S_FIN.
// Reset (synchronous, active low): list table null/zero, counters zero,
// no result pending. Node memories are not cleared; no clearing pass.
`timescale 1ns / 1ps

module pooled_linked_list_manager_top
    import pllm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // request: [2:0] operation, [5:3] list_id, [8:6] other_list_id,
    //          [40:9] item_value, rest zero
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result: [2:0] status, [5:3] new_list, [13:6] list_length, rest zero
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,   // take a request
        S_DEC,    // read list A, check, issue node read
        S_LINK1,  // node read back: write the new node's links
        S_CATB,   // read list B for concat
        S_FIN     // commit and load the result register
    } t_state;

    // what S_FIN has to commit
    typedef enum logic [2:0] {
        K_NONE,    // result only
        K_CREATE,
        K_EMPTY,   // first node of an empty list
        K_NOLINK,  // cursor/anchor null: node taken, nothing linked
        K_LINK,
        K_CAT
    } t_kind;

    // list table
    t_ptr r_head [MAX_LISTS];
    t_ptr r_tail [MAX_LISTS];
    t_ptr r_cur  [MAX_LISTS];
    t_cnt r_cnt  [MAX_LISTS];

    logic [LC_W-1:0] r_lists;
    t_ptr            r_used;

    // node memories
    t_ptr                  fwd_mem  [POOL_NODES];
    t_ptr                  bwd_mem  [POOL_NODES];
    logic [ITEM_WIDTH-1:0] item_mem [POOL_NODES];
    t_ptr                  r_fwd_rd;
    t_ptr                  r_bwd_rd;

    t_state r_state;
    t_kind  r_kind;

    // latched request
    t_op                   r_op;
    logic [LIX_W-1:0]      r_a;
    logic [LIX_W-1:0]      r_b;
    logic [ITEM_WIDTH-1:0] r_item;

    // snapshot of list A / B and link work
    t_ptr r_atail;
    t_cnt r_acnt;
    t_ptr r_bhead, r_btail, r_bcur;
    t_cnt r_bcnt;
    t_ptr r_at;      // anchor node
    t_ptr r_nb;      // its neighbor on the linking side
    t_ptr r_n;       // new node
    logic r_after;   // link after anchor (else before)

    t_status          r_status;
    logic [LIX_W-1:0] r_newl;
    t_cnt             r_len;

    logic                   r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;

    // list table read port
    logic [LIX_W-1:0] l_idx;
    t_ptr             l_head, l_tail, l_cur;
    t_cnt             l_cnt;

    logic a_ok, b_ok, pool_full, out_free;
    t_ptr at_ptr;
    t_ptr nb_ptr;
    t_cnt len_fin;

    logic             fwd_we, bwd_we, item_we;
    logic [IDX_W-1:0] fwd_wa, bwd_wa, rd_addr;
    t_ptr             fwd_wd, bwd_wd;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign out_free      = !r_ovalid || m_axis_tready;

    assign l_idx  = (r_state == S_CATB) ? r_b : r_a;
    assign l_head = r_head[l_idx];
    assign l_tail = r_tail[l_idx];
    assign l_cur  = r_cur[l_idx];
    assign l_cnt  = r_cnt[l_idx];

    assign a_ok      = {1'b0, r_a} < r_lists;
    assign b_ok      = {1'b0, r_b} < r_lists;
    assign pool_full = (r_used >= NIL);

    // anchor: cursor for add/insert, tail for append, head for prepend
    always_comb begin
        case (r_op)
            OP_APPEND:  at_ptr = l_tail;
            OP_PREPEND: at_ptr = l_head;
            default:    at_ptr = l_cur;
        endcase
    end

    assign rd_addr = at_ptr[IDX_W-1:0];
    assign nb_ptr  = r_after ? r_fwd_rd : r_bwd_rd;

    always_comb begin
        case (r_kind) inside
            K_EMPTY, K_NOLINK, K_LINK: len_fin = r_acnt + t_cnt'(1);
            K_CAT:                     len_fin = r_acnt + r_bcnt;
            default:                   len_fin = r_len;
        endcase
    end

    // memory write ports
    always_comb begin
        fwd_we  = 1'b0;
        fwd_wa  = r_n[IDX_W-1:0];
        fwd_wd  = NIL;
        bwd_we  = 1'b0;
        bwd_wa  = r_n[IDX_W-1:0];
        bwd_wd  = NIL;
        item_we = 1'b0;
        if (r_state == S_LINK1) begin
            // new node's own links
            fwd_we = 1'b1;
            bwd_we = 1'b1;
            fwd_wd = r_after ? nb_ptr : r_at;
            bwd_wd = r_after ? r_at : nb_ptr;
        end else if (r_state == S_FIN && out_free) begin
            unique case (r_kind) inside
                K_EMPTY, K_NOLINK: begin
                    fwd_we  = 1'b1;
                    bwd_we  = 1'b1;
                    item_we = 1'b1;
                end
                K_LINK: begin
                    item_we = 1'b1;
                    if (r_after) begin
                        fwd_we = 1'b1;
                        fwd_wa = r_at[IDX_W-1:0];
                        fwd_wd = r_n;
                        bwd_we = (r_nb < NIL);
                        bwd_wa = r_nb[IDX_W-1:0];
                        bwd_wd = r_n;
                    end else begin
                        bwd_we = 1'b1;
                        bwd_wa = r_at[IDX_W-1:0];
                        bwd_wd = r_n;
                        fwd_we = (r_nb < NIL);
                        fwd_wa = r_nb[IDX_W-1:0];
                        fwd_wd = r_n;
                    end
                end
                K_CAT: begin
                    if (r_acnt != '0 && r_bcnt != '0 && r_atail < NIL && r_bhead < NIL) begin
                        fwd_we = 1'b1;
                        fwd_wa = r_atail[IDX_W-1:0];
                        fwd_wd = r_bhead;
                        bwd_we = 1'b1;
                        bwd_wa = r_bhead[IDX_W-1:0];
                        bwd_wd = r_atail;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            fwd_mem[fwd_wa] <= fwd_wd;
        end
        r_fwd_rd <= fwd_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (bwd_we) begin
            bwd_mem[bwd_wa] <= bwd_wd;
        end
        r_bwd_rd <= bwd_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (item_we) begin
            item_mem[r_n[IDX_W-1:0]] <= r_item;
        end
    end

    // control, list table and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_kind   <= K_NONE;
            r_lists  <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < MAX_LISTS; i++) begin
                r_head[i] <= NIL;
                r_tail[i] <= NIL;
                r_cur[i]  <= NIL;
                r_cnt[i]  <= '0;
            end
        end else begin
            if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_op    <= t_op'(s_axis_tdata[OP_W-1:0]);
                        r_a     <= s_axis_tdata[OP_W +: LID_W];
                        r_b     <= s_axis_tdata[OP_W + LID_W +: LID_W];
                        r_item  <= s_axis_tdata[OP_W + 2 * LID_W +: ITEM_WIDTH];
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_atail  <= l_tail;
                    r_acnt   <= l_cnt;
                    r_at     <= at_ptr;
                    r_n      <= r_used;
                    r_after  <= (r_op == OP_ADD) || (r_op == OP_APPEND);
                    r_status <= ST_OK;
                    r_newl   <= '0;
                    r_len    <= '0;
                    r_kind   <= K_NONE;
                    r_state  <= S_FIN;
                    unique case (r_op) inside
                        OP_CREATE: begin
                            if (r_lists >= LC_W'(MAX_LISTS)) begin
                                r_status <= ST_TABLE_FULL;
                            end else begin
                                r_kind <= K_CREATE;
                                r_newl <= r_lists[LIX_W-1:0];
                            end
                        end
                        OP_ADD, OP_INSERT, OP_APPEND, OP_PREPEND: begin
                            if (!a_ok) begin
                                r_status <= ST_NO_LIST;
                            end else if (pool_full) begin
                                r_status <= ST_POOL_FULL;
                                r_len    <= l_cnt;
                            end else if (l_cnt == '0 || l_head >= NIL) begin
                                r_kind <= K_EMPTY;
                            end else if (at_ptr >= NIL) begin
                                r_kind <= K_NOLINK;
                            end else begin
                                r_kind  <= K_LINK;
                                r_state <= S_LINK1;
                            end
                        end
                        OP_CONCAT: begin
                            if (!a_ok || !b_ok) begin
                                r_status <= ST_NO_LIST;
                                r_len    <= a_ok ? l_cnt : '0;
                            end else if (r_a == r_b) begin
                                r_status <= ST_SAME_LIST;
                                r_len    <= l_cnt;
                            end else begin
                                r_kind  <= K_CAT;
                                r_state <= S_CATB;
                            end
                        end
                        default: ;  // unused codes: no change, zero result
                    endcase
                end
                S_LINK1: begin
                    r_nb    <= nb_ptr;
                    r_state <= S_FIN;
                end
                S_CATB: begin
                    r_bhead <= l_head;
                    r_btail <= l_tail;
                    r_bcur  <= l_cur;
                    r_bcnt  <= l_cnt;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        unique case (r_kind)
                            K_CREATE: begin
                                r_head[r_newl] <= NIL;
                                r_tail[r_newl] <= NIL;
                                r_cur[r_newl]  <= NIL;
                                r_cnt[r_newl]  <= '0;
                                r_lists        <= r_lists + LC_W'(1);
                            end
                            K_EMPTY: begin
                                r_head[r_a] <= r_n;
                                r_tail[r_a] <= r_n;
                                r_cur[r_a]  <= r_n;
                                r_cnt[r_a]  <= len_fin;
                                r_used      <= r_used + t_ptr'(1);
                            end
                            K_NOLINK: begin
                                r_cur[r_a] <= r_n;
                                r_cnt[r_a] <= len_fin;
                                r_used     <= r_used + t_ptr'(1);
                            end
                            K_LINK: begin
                                r_cur[r_a] <= r_n;
                                r_cnt[r_a] <= len_fin;
                                r_used     <= r_used + t_ptr'(1);
                                // anchor was an end node: new node is the new end
                                if (r_nb >= NIL) begin
                                    if (r_after) begin
                                        r_tail[r_a] <= r_n;
                                    end else begin
                                        r_head[r_a] <= r_n;
                                    end
                                end
                            end
                            K_CAT: begin
                                if (r_acnt == '0) begin
                                    r_head[r_a] <= r_bhead;
                                    r_tail[r_a] <= r_btail;
                                    r_cur[r_a]  <= r_bcur;
                                end else if (r_bcnt != '0 && r_atail < NIL && r_bhead < NIL) begin
                                    r_tail[r_a] <= r_btail;
                                end
                                r_cnt[r_a]  <= len_fin;
                                r_head[r_b] <= NIL;
                                r_tail[r_b] <= NIL;
                                r_cur[r_b]  <= NIL;
                                r_cnt[r_b]  <= '0;
                            end
                            default: ;
                        endcase
                        r_ovalid <= 1'b1;
                        r_odata  <= OUT_TDATA_W'({LEN_W'(len_fin), r_newl, r_status});
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
